FILE: hw/rtl/cpst_pkg.sv
// Package with shared types and codes for the call-path state tracker.
`timescale 1ns / 1ps
package cpst_pkg;
    localparam int TABLE_SLOTS  = 1024;
    localparam int STACK_DEPTH  = 64;
    localparam int STATE_BITS   = 16;
    localparam int COUNTER_BITS = 16;

    localparam int OP_BITS    = 3;
    localparam int SLOT_BITS  = $clog2(TABLE_SLOTS);
    localparam int SRC_BITS   = STATE_BITS;
    localparam int INSTR_BITS = 31;
    localparam int TGT_BITS   = STATE_BITS;
    localparam int DEPTH_BITS = $clog2(STACK_DEPTH + 1);
    localparam int TOP_BITS   = COUNTER_BITS;

    typedef enum logic [2:0] {
        OP_LOAD   = 3'd0,
        OP_CALL   = 3'd1,
        OP_EXIT   = 3'd2,
        OP_UPDATE = 3'd3,
        OP_INIT   = 3'd4
    } t_op;

    typedef enum logic [3:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_TOP_RD,
        ST_TOP_WAIT,
        ST_SCAN1,
        ST_SCAN2,
        ST_FINISH,
        ST_STK_WR,
        ST_INIT_CLR,
        ST_OUT_RD,
        ST_OUT_WAIT,
        ST_OUT
    } t_state;
endpackage

FILE: hw/rtl/cpst_if.sv
// Valid/ready channel interfaces for the tracker input and result.
`timescale 1ns / 1ps
interface cpst_in_if;
    import cpst_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [OP_BITS-1:0]    operation;
    logic [SLOT_BITS-1:0]  entry_slot;
    logic [SRC_BITS-1:0]   source_state;
    logic [INSTR_BITS-1:0] instruction_id;
    logic [TGT_BITS-1:0]   target_state;
    logic                  entry_valid;
    modport source (output valid, operation, entry_slot, source_state, instruction_id,
                    target_state, entry_valid, input ready);
    modport sink (input valid, operation, entry_slot, source_state, instruction_id,
                  target_state, entry_valid, output ready);
endinterface

interface cpst_out_if;
    import cpst_pkg::*;
    logic                  valid;
    logic                  ready;
    logic [TGT_BITS-1:0]   current_state;
    logic [DEPTH_BITS-1:0] nesting_depth;
    logic [TOP_BITS-1:0]   top_counter;
    logic                  state_moved;
    logic                  exit_not_found;
    logic                  stack_fault;
    modport source (output valid, current_state, nesting_depth, top_counter, state_moved,
                    exit_not_found, stack_fault, input ready);
    modport sink (input valid, current_state, nesting_depth, top_counter, state_moved,
                  exit_not_found, stack_fault, output ready);
endinterface

FILE: hw/rtl/call_path_state_tracker.sv
// Top level of the call-path state tracker.
//
// One input channel (i_in) carries operation items, one output channel
// (o_out) returns exactly one result per item. Items are processed one at a
// time; the input is ready only while the sequencer is idle.
// A load or an unused code goes through the output read states to its
// result. A call, exit or update with a nonzero top counter goes from the
// top counter read straight to the stack write. Otherwise it scans the
// transition memory one slot per cycle, once for the (state, instruction)
// match and, for call and update after such a match, once more for the
// fallthrough; the scan stops at the first match.
// Initialize clears the counter stack memory before its result.
// After reset a clearing pass zeroes the transition memory, valid bits
// included, and the counter stack before the first item is taken.
// A result is held in the output register until the receiver takes it; the
// next item is still accepted and processed, and its result waits in the
// last sequencer state until the output register is free.
`timescale 1ns / 1ps
module call_path_state_tracker
    import cpst_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    cpst_in_if.sink    i_in,
    cpst_out_if.source o_out
);
    localparam int TW = $clog2(TABLE_SLOTS);
    localparam int SW = $clog2(STACK_DEPTH);
    localparam int CW = $clog2(STACK_DEPTH + 1);
    localparam int EW = 1 + STATE_BITS + INSTR_BITS + STATE_BITS;
    localparam int CLRW = (TW > SW) ? TW + 1 : SW + 1;
    localparam logic [COUNTER_BITS-1:0] CNT_MAX = '1;

    t_state r_st, n_st;

    logic [OP_BITS-1:0]    r_op;
    logic [INSTR_BITS-1:0] r_instr;
    logic [STATE_BITS-1:0] r_pres, n_pres;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [COUNTER_BITS-1:0] r_top;
    logic [STATE_BITS-1:0] r_key, r_first;
    logic                  r_moved, r_nf, r_fault;
    logic [CLRW-1:0]       r_idx, n_idx;
    logic                  r_chk, n_chk;
    logic                  r_vld;
    logic [TGT_BITS-1:0]   r_o_state;
    logic [DEPTH_BITS-1:0] r_o_depth;
    logic [TOP_BITS-1:0]   r_o_top;
    logic                  r_o_moved, r_o_nf, r_o_fault;

    // table memory
    logic          t_we;
    logic [TW-1:0] t_waddr, t_raddr;
    logic [EW-1:0] t_wdata, t_rdata;
    // stack memory
    logic                    s_we;
    logic [SW-1:0]           s_waddr, s_raddr;
    logic [COUNTER_BITS-1:0] s_wdata, s_rdata;

    cpst_ram #(.WIDTH(EW), .DEPTH(TABLE_SLOTS)) u_table (
        .i_clk(i_clk), .i_we(t_we), .i_waddr(t_waddr), .i_wdata(t_wdata),
        .i_raddr(t_raddr), .o_rdata(t_rdata));
    cpst_ram #(.WIDTH(COUNTER_BITS), .DEPTH(STACK_DEPTH)) u_stack (
        .i_clk(i_clk), .i_we(s_we), .i_waddr(s_waddr), .i_wdata(s_wdata),
        .i_raddr(s_raddr), .o_rdata(s_rdata));

    logic              e_v;
    logic [STATE_BITS-1:0] e_src, e_tgt;
    logic [INSTR_BITS-1:0] e_ins;
    assign {e_v, e_src, e_ins, e_tgt} = t_rdata;

    logic [SW-1:0] top_idx;
    assign top_idx = SW'(r_cnt - CW'(1));

    logic last_slot, hit1, hit2;
    assign last_slot = (r_idx[TW-1:0] == TW'(TABLE_SLOTS - 1));
    assign hit1 = r_chk && e_v && (e_src == r_key) && (e_ins == r_instr);
    assign hit2 = r_chk && e_v && (e_src == r_key) && (e_ins == '0);

    logic slot_ok;
    assign slot_ok = (32'(i_in.entry_slot) < 32'(TABLE_SLOTS));

    // load the output register once it is free
    logic out_load;
    assign out_load = (r_st == ST_OUT) && (!r_vld || o_out.ready);

    assign i_in.ready = (r_st == ST_IDLE);

    // next state and memory control
    always_comb begin
        n_st   = r_st;
        n_pres = r_pres;
        n_cnt  = r_cnt;
        n_idx  = r_idx;
        n_chk  = 1'b0;
        t_we = 1'b0; t_waddr = r_idx[TW-1:0]; t_wdata = '0;
        t_raddr = r_idx[TW-1:0];
        s_we = 1'b0; s_waddr = top_idx; s_wdata = '0; s_raddr = top_idx;
        case (r_st)
            ST_CLEAR: begin
                t_we = 1'b1;
                s_we = 1'b1; s_waddr = r_idx[SW-1:0];
                n_idx = r_idx + CLRW'(1);
                if (last_slot) n_st = ST_IDLE;
            end
            ST_IDLE: begin
                if (i_in.valid && i_in.ready) begin
                    n_idx = '0;
                    case (t_op'(i_in.operation))
                        OP_LOAD: begin
                            t_we = slot_ok;
                            t_waddr = i_in.entry_slot[TW-1:0];
                            t_wdata = {i_in.entry_valid, i_in.source_state[STATE_BITS-1:0],
                                       i_in.instruction_id,
                                       i_in.target_state[STATE_BITS-1:0]};
                            n_st = ST_OUT_RD;
                        end
                        OP_CALL, OP_EXIT, OP_UPDATE: n_st = ST_TOP_RD;
                        OP_INIT: begin
                            n_pres = i_in.source_state[STATE_BITS-1:0];
                            n_cnt = CW'(1);
                            n_st = ST_INIT_CLR;
                        end
                        default: n_st = ST_OUT_RD;
                    endcase
                end
            end
            ST_TOP_RD: n_st = ST_TOP_WAIT;
            ST_TOP_WAIT: begin
                if (s_rdata != '0) n_st = ST_STK_WR;
                else begin
                    n_st = ST_SCAN1;
                    t_raddr = '0;
                    n_idx = CLRW'(1);
                    n_chk = 1'b1;
                end
            end
            ST_SCAN1: begin
                n_chk = 1'b1;
                n_idx = r_idx + CLRW'(1);
                if (hit1) begin
                    if (t_op'(r_op) == OP_EXIT) n_st = ST_FINISH;
                    else begin
                        n_st = ST_SCAN2;
                        t_raddr = '0;
                        n_idx = CLRW'(1);
                    end
                end else if (r_idx == CLRW'(TABLE_SLOTS)) n_st = ST_FINISH;
            end
            ST_SCAN2: begin
                n_chk = 1'b1;
                n_idx = r_idx + CLRW'(1);
                if (hit2 || r_idx == CLRW'(TABLE_SLOTS)) n_st = ST_FINISH;
            end
            ST_FINISH: n_st = ST_STK_WR;
            ST_STK_WR: begin
                s_we = 1'b1;
                n_st = ST_OUT_RD;
                if (t_op'(r_op) == OP_CALL) begin
                    if (r_moved) begin
                        s_waddr = SW'(r_cnt);
                        s_wdata = '0;
                        s_we = !r_fault;
                        if (!r_fault) n_cnt = r_cnt + CW'(1);
                    end else begin
                        s_wdata = r_top + COUNTER_BITS'(1);
                        s_we = !r_fault;
                    end
                end else if (t_op'(r_op) == OP_EXIT) begin
                    if (r_top != '0) s_wdata = r_top - COUNTER_BITS'(1);
                    else begin
                        s_we = 1'b0;
                        if (r_moved && r_cnt > CW'(1)) n_cnt = r_cnt - CW'(1);
                    end
                end else s_we = 1'b0;
                if (r_moved) n_pres = r_first;
            end
            ST_INIT_CLR: begin
                s_we = 1'b1; s_waddr = r_idx[SW-1:0];
                n_idx = r_idx + CLRW'(1);
                if (r_idx[SW-1:0] == SW'(STACK_DEPTH - 1)) n_st = ST_OUT_RD;
            end
            ST_OUT_RD: n_st = ST_OUT_WAIT;
            ST_OUT_WAIT: n_st = ST_OUT;
            ST_OUT: begin
                if (out_load) n_st = ST_IDLE;
            end
            default: n_st = ST_IDLE;
        endcase
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= ST_CLEAR;
            r_pres <= '0;
            r_cnt <= CW'(1);
            r_idx <= '0;
            r_chk <= 1'b0;
            r_vld <= 1'b0;
        end else begin
            r_st  <= n_st;
            r_pres <= n_pres;
            r_cnt <= n_cnt;
            r_idx <= n_idx;
            r_chk <= n_chk;
            if (out_load) r_vld <= 1'b1;
            else if (o_out.ready) r_vld <= 1'b0;
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (r_st == ST_IDLE && i_in.valid && i_in.ready) begin
            r_op <= i_in.operation;
            r_instr <= i_in.instruction_id;
            r_key <= r_pres;
            r_moved <= 1'b0; r_nf <= 1'b0; r_fault <= 1'b0;
        end
        if (r_st == ST_TOP_WAIT) begin
            r_top <= s_rdata;
        end
        if (r_st == ST_SCAN1 && hit1) begin
            r_first <= e_tgt;
            r_key <= e_tgt;
            r_moved <= 1'b1;
        end
        if (r_st == ST_SCAN2 && hit2) begin
            r_first <= e_tgt;
        end
        if (r_st == ST_FINISH) begin
            if (t_op'(r_op) == OP_CALL) begin
                r_fault <= r_moved ? (r_cnt == CW'(STACK_DEPTH)) : (r_top == CNT_MAX);
            end else if (t_op'(r_op) == OP_EXIT) begin
                r_nf <= !r_moved;
                r_fault <= r_moved && (r_cnt == CW'(1));
            end
        end
        if (r_st == ST_TOP_WAIT && s_rdata != '0 && t_op'(r_op) == OP_CALL) begin
            r_fault <= (s_rdata == CNT_MAX);
        end
        if (out_load) begin
            r_o_state <= TGT_BITS'(r_pres);
            r_o_depth <= DEPTH_BITS'(r_cnt);
            r_o_top <= TOP_BITS'(s_rdata);
            r_o_moved <= r_moved && (t_op'(r_op) == OP_CALL || t_op'(r_op) == OP_EXIT ||
                                     t_op'(r_op) == OP_UPDATE);
            r_o_nf <= r_nf && (t_op'(r_op) == OP_EXIT);
            r_o_fault <= r_fault && (t_op'(r_op) == OP_CALL || t_op'(r_op) == OP_EXIT);
        end
    end

    assign o_out.valid = r_vld;
    assign o_out.current_state = r_o_state;
    assign o_out.nesting_depth = r_o_depth;
    assign o_out.top_counter = r_o_top;
    assign o_out.state_moved = r_o_moved;
    assign o_out.exit_not_found = r_o_nf;
    assign o_out.stack_fault = r_o_fault;

    // checks
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cnt >= CW'(1) && r_cnt <= CW'(STACK_DEPTH)) else $error("depth out of range");
    a_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !o_out.ready |=> $stable(r_o_state) && $stable(r_o_top))
        else $error("result changed while stalled");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld && !o_out.ready |=> r_vld) else $error("result dropped");
endmodule

FILE: hw/rtl/cpst_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
`timescale 1ns / 1ps
module cpst_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    // write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
